// ===== rtl/core/preemptive_priority_scheduler_top_assert.svh =====
// assertion macros shared by the scheduler rtl
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_TOP_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication
`define PPS_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pps_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = $clog2(SLOTS);

	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic [7:0]  label;
		logic [7:0]  prio;
		logic [15:0] burst;
		logic [15:0] arrival;
		logic [15:0] remaining;
	} slot_word_t;

	typedef struct packed {
		logic load;
		logic arrive;
		logic scan_rd;
		logic pick_rd;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
	} stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/pps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/pps_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "preemptive_priority_scheduler_top_assert.svh"
module pps_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          opcode,
	input  wire pps_pkg::stat_t stat,
	output pps_pkg::cmd_t      cmd,
	output logic               busy
);
	import pps_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ARRIVE,
		S_SCAN,
		S_DRAIN,
		S_PICK,
		S_COMMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= (opcode == OP_ARRIVE) ? S_ARRIVE : S_SCAN;
					end
				end
				S_ARRIVE: state_q <= S_IDLE;
				S_SCAN: begin
					if (stat.scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN:  state_q <= S_PICK;
				S_PICK:   state_q <= S_COMMIT;
				S_COMMIT: state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:   cmd.load    = start;
			S_ARRIVE: cmd.arrive  = 1'b1;
			S_SCAN:   cmd.scan_rd = 1'b1;
			S_PICK:   cmd.pick_rd = 1'b1;
			S_COMMIT: cmd.commit  = 1'b1;
			default:  cmd = '0;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	`PPS_ASSERT_NXT(a_idle_holds, clk, arst_n, (state_q == S_IDLE) && !start, state_q == S_IDLE, "left idle without start")
	`PPS_ASSERT_NXT(a_finish_idle, clk, arst_n, cmd.arrive || cmd.commit, !busy, "not idle after a word finished")
	`PPS_ASSERT_NOW(a_load_idle, clk, arst_n, cmd.load, !busy, "load while busy")

endmodule
`default_nettype wire

// ===== rtl/core/pps_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "preemptive_priority_scheduler_top_assert.svh"
module pps_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pps_pkg::cmd_t cmd,
	output pps_pkg::stat_t     stat,
	input  wire logic [7:0]    job_name,
	input  wire logic [7:0]    job_priority,
	input  wire logic [15:0]   job_burst,
	output logic               strobe,
	output logic               kind,
	output logic               accepted,
	output logic               running_valid,
	output logic [7:0]         running_name,
	output logic               finished,
	output logic [15:0]        turnaround,
	output logic [15:0]        wait_time,
	output logic [15:0]        now_time
);
	import pps_pkg::*;

	logic [SLOTS-1:0]  valid_q;
	logic [15:0]       clock_q;
	logic [SLOT_W-1:0] run_slot_q;
	logic              run_active_q;

	logic [7:0]        name_q;
	logic [7:0]        prio_q;
	logic [15:0]       burst_q;

	logic [SLOT_W-1:0] scan_idx_q;
	logic [SLOT_W-1:0] idx_s1;
	logic              rd_s1;
	logic              best_found_q;
	logic [SLOT_W-1:0] best_idx_q;
	logic [7:0]        best_prio_q;
	logic [7:0]        run_prio_q;
	logic [SLOT_W-1:0] sel_q;

	logic              strobe_q;

	logic                     ram_we;
	logic [SLOT_W-1:0]        ram_waddr;
	logic [SLOT_W-1:0]        ram_raddr;
	slot_word_t               wword;
	slot_word_t               rword;
	logic [$bits(slot_word_t)-1:0] ram_rdata;

	logic              free_any;
	logic [SLOT_W-1:0] free_idx;
	logic              run_keep;
	logic [SLOT_W-1:0] pick_idx;
	logic [15:0]       clock_inc;
	logic              fin;
	logic [15:0]       ta;
	logic [15:0]       wt;

	// lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	// running job keeps the cpu on a priority tie
	assign run_keep = run_active_q && valid_q[run_slot_q] && (run_prio_q == best_prio_q);
	assign pick_idx = run_keep ? run_slot_q : best_idx_q;

	assign clock_inc = (clock_q == 16'hFFFF) ? clock_q : clock_q + 16'd1;

	assign rword = slot_word_t'(ram_rdata);
	assign fin   = (rword.remaining <= 16'd1);
	assign ta    = clock_inc - rword.arrival;
	assign wt    = (ta >= rword.burst) ? ta - rword.burst : 16'd0;

	assign stat.scan_last = (scan_idx_q == SLOT_W'(SLOTS - 1));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = free_idx;
		wword     = '{label: name_q, prio: prio_q, burst: burst_q,
			arrival: clock_q, remaining: burst_q};
		if (cmd.arrive) begin
			ram_we = free_any;
		end else if (cmd.commit) begin
			ram_we          = best_found_q && !fin;
			ram_waddr       = sel_q;
			wword           = rword;
			wword.remaining = rword.remaining - 16'd1;
		end
	end

	assign ram_raddr = cmd.pick_rd ? pick_idx : scan_idx_q;

	pps_ram #(
		.WIDTH($bits(slot_word_t)),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wword),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			clock_q      <= '0;
			run_slot_q   <= '0;
			run_active_q <= 1'b0;
			scan_idx_q   <= '0;
			rd_s1        <= 1'b0;
			best_found_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= cmd.arrive || cmd.commit;
			rd_s1    <= cmd.scan_rd;
			if (cmd.load) begin
				scan_idx_q   <= '0;
				best_found_q <= 1'b0;
			end
			if (cmd.scan_rd) begin
				scan_idx_q <= scan_idx_q + SLOT_W'(1);
			end
			if (rd_s1 && valid_q[idx_s1] && (!best_found_q || rword.prio < best_prio_q)) begin
				best_found_q <= 1'b1;
			end
			if (cmd.arrive && free_any) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (cmd.commit) begin
				clock_q <= clock_inc;
				if (best_found_q) begin
					if (fin) begin
						valid_q[sel_q] <= 1'b0;
						run_active_q   <= 1'b0;
					end else begin
						run_slot_q   <= sel_q;
						run_active_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			name_q  <= job_name;
			prio_q  <= job_priority;
			burst_q <= job_burst;
		end
		idx_s1 <= scan_idx_q;
		if (rd_s1 && valid_q[idx_s1] && (!best_found_q || rword.prio < best_prio_q)) begin
			best_idx_q  <= idx_s1;
			best_prio_q <= rword.prio;
		end
		if (rd_s1 && (idx_s1 == run_slot_q)) begin
			run_prio_q <= rword.prio;
		end
		if (cmd.pick_rd) begin
			sel_q <= pick_idx;
		end
		if (cmd.arrive) begin
			kind          <= KIND_ACK;
			accepted      <= free_any;
			running_valid <= 1'b0;
			running_name  <= '0;
			finished      <= 1'b0;
			turnaround    <= '0;
			wait_time     <= '0;
			now_time      <= clock_q;
		end else if (cmd.commit) begin
			kind          <= KIND_TICK;
			accepted      <= 1'b0;
			running_valid <= best_found_q;
			running_name  <= best_found_q ? rword.label : 8'd0;
			finished      <= best_found_q && fin;
			turnaround    <= (best_found_q && fin) ? ta : 16'd0;
			wait_time     <= (best_found_q && fin) ? wt : 16'd0;
			now_time      <= clock_inc;
		end
	end

	assign strobe = strobe_q;

	`PPS_ASSERT_NOW(a_strobe_src, clk, arst_n, strobe_q, $past(cmd.arrive || cmd.commit), "strobe without a finished word")
	`PPS_ASSERT_NOW(a_fin_frees, clk, arst_n, strobe_q && finished, !run_active_q, "finished job still marked running")
	`PPS_ASSERT_NXT(a_clock_mono, clk, arst_n, 1'b1, clock_q >= $past(clock_q), "time went backward")

endmodule
`default_nettype wire

// ===== rtl/core/preemptive_priority_scheduler_top.sv =====
// arrival word: idle accepts it, the arrive state writes a free slot, the result strobe is registered from arrive
// tick word: slot table scanned one entry per cycle from a ram with one read port,
//   then drain, pick and commit states, result strobe registered from commit
// a new word is taken only back in idle; results are strobed for one cycle; the receiver cannot stall them
// reset (arst_n low, asynchronous): all slots free, time 0, no job running
`timescale 1ns / 1ps
`default_nettype none
module preemptive_priority_scheduler_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        opcode,
	input  wire logic [7:0]  job_name,
	input  wire logic [7:0]  job_priority,
	input  wire logic [15:0] job_burst,
	output logic             strobe,
	output logic             kind,
	output logic             accepted,
	output logic             running_valid,
	output logic [7:0]       running_name,
	output logic             finished,
	output logic [15:0]      turnaround,
	output logic [15:0]      wait_time,
	output logic [15:0]      now_time
);
	import pps_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	pps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	pps_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.job_name      (job_name),
		.job_priority  (job_priority),
		.job_burst     (job_burst),
		.strobe        (strobe),
		.kind          (kind),
		.accepted      (accepted),
		.running_valid (running_valid),
		.running_name  (running_name),
		.finished      (finished),
		.turnaround    (turnaround),
		.wait_time     (wait_time),
		.now_time      (now_time)
	);

endmodule
`default_nettype wire
